>>> hw/rtl/vgn_pkg.sv
package vgn_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int SIZE_W    = 9;
    localparam int POS_W     = 8;
    localparam int PLANE_W   = 9;
    localparam int ADDR_W    = 1 + 2 * POS_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int DIFF_W    = SAMPLE_W + 1;
    localparam int GRAD_W    = 33;
    localparam int SUM_W     = 34;
    localparam int ROOT_W    = 63;
    localparam int QUOT_W    = 31;
    localparam int REM_W     = 32;
    localparam int PREC_SH   = 14;
    localparam int TDATA_W   = 104;
    localparam int NUM_TAPS  = 6;

    localparam logic [SIZE_W-1:0] MAX_X = 9'd256;
    localparam logic [SIZE_W-1:0] MAX_Y = 9'd256;
    localparam logic [SIZE_W-1:0] MAX_Z = 9'd256;

    localparam logic [1:0] REG_X_SIZE = 2'd0;
    localparam logic [1:0] REG_Y_SIZE = 2'd1;
    localparam logic [1:0] REG_Z_SIZE = 2'd2;
    localparam logic [1:0] REG_FORMAT = 2'd3;

    localparam logic [1:0] FMT_BYTE = 2'd0;
    localparam logic [1:0] FMT_HALF = 2'd1;
    localparam logic [1:0] FMT_WORD = 2'd2;
    localparam logic [1:0] FMT_RAW  = 2'd3;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    localparam logic [31:0] SCALE_BYTE = 32'd127;
    localparam logic [31:0] SCALE_HALF = 32'd32767;
    localparam logic [31:0] SCALE_WORD = 32'd2147483647;

    typedef enum logic [1:0] {
        T_IDLE,
        T_READ,
        T_CALC,
        T_OUT
    } top_state_t;

    typedef enum logic [2:0] {
        C_IDLE,
        C_SQ,
        C_RINIT,
        C_SQRT,
        C_DINIT,
        C_DIV,
        C_SCALE,
        C_DONE
    } core_state_t;

    typedef struct packed {
        logic       start;
        logic [1:0] fmt;
    } core_req_t;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] max);
        logic [SIZE_W-1:0] r;
        if (v == '0)
            r = SIZE_W'(1);
        else if (v > max)
            r = max;
        else
            r = v;
        return r;
    endfunction

endpackage

>>> hw/rtl/volume_gradient_normalize.sv
// Streaming 3-D central-difference gradient with unit-length normalisation.
// Input channel (s_*): one transfer per voxel in raster order, x fastest,
// then y, then z. s_tuser is the op (0 sample, 1 flush), s_tdata the sample.
// Output channel (m_*): one transfer per gradient; m_tlast marks the final
// voxel of the volume. Results trail the input by one plane; after the last
// plane, X*Y flush transfers drain it. Samples before the first plane is
// complete, samples during drain and early flushes produce no result.
// Configuration: cfg_we/cfg_addr/cfg_data write x_size, y_size, z_size and
// output_format. A size write restarts the volume; write only when idle.
// Sequence: after the transfer, six neighbours are read and the sample is
// stored; the core then forms three squares in the multiplier, a 32-step
// square root and three 31-step divisions in the shared subtract/compare
// unit, each division followed by a scaling multiply, and the output
// register is loaded: m_tvalid rises when s_tready returns. Samples of the
// first plane only read and store; dropped items are taken while idle.
// The result waits in an output register, so a stalled receiver does not
// block acceptance of the next item; only a second finished result waits.
// Reset clears positions, sets sizes to 256 and the format to byte scale;
// the plane store is not cleared; each read feeding a result hits this volume.
module volume_gradient_normalize (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [vgn_pkg::SAMPLE_W-1:0] s_tdata,  // [15:0] sample
    input  logic                         s_tuser,  // [0] op
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [vgn_pkg::TDATA_W-1:0]  m_tdata,  // [32:0] grad_x, [65:33] grad_y,
                                                   // [98:66] grad_z, rest zero
    output logic                         m_tlast,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_addr,
    input  logic [vgn_pkg::SIZE_W-1:0]   cfg_data
);
    import vgn_pkg::*;

    top_state_t          state_reg, state_next;
    logic [SIZE_W-1:0]   x_size_reg, y_size_reg, z_size_reg;
    logic [1:0]          fmt_reg;
    logic [POS_W-1:0]    col_reg, row_reg;
    logic [PLANE_W-1:0]  plane_reg;
    logic                op_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [2:0]          rc_reg;
    logic [SAMPLE_W-1:0] tap_reg [0:NUM_TAPS-1];
    logic                last_reg;
    logic                tlast_reg;
    logic                mvalid_reg;
    logic [TDATA_W-1:0]  mdata_reg;

    logic [SIZE_W-1:0]   x_eff, y_eff, z_eff;
    logic [PLANE_W-1:0]  k;
    logic                c, bslot;
    logic [SIZE_W-1:0]   col_ext, row_ext, ip, jp;
    logic [POS_W-1:0]    im, jm;
    logic [ADDR_W-1:0]   raddr, waddr;
    logic [SAMPLE_W-1:0] rdata, above;
    logic                we, in_fire, has_res, col_wrap, row_wrap, drain_end;
    logic signed [DIFF_W-1:0] dx, dy, dz;
    core_req_t           req;
    logic                core_done;
    logic [GRAD_W-1:0]   gx, gy, gz;

    assign x_eff = eff_size(x_size_reg, MAX_X);
    assign y_eff = eff_size(y_size_reg, MAX_Y);
    assign z_eff = eff_size(z_size_reg, MAX_Z);

    // plane being finished: z_size-1 while draining, else the previous one
    assign k     = (op_reg == OP_FLUSH) ? z_eff - PLANE_W'(1) : plane_reg - PLANE_W'(1);
    assign c     = k[0];
    assign bslot = (k == '0) ? c : ~c;

    assign col_ext = {1'b0, col_reg};
    assign row_ext = {1'b0, row_reg};
    assign ip = (col_ext + SIZE_W'(1) < x_eff) ? col_ext + SIZE_W'(1) : x_eff - SIZE_W'(1);
    assign jp = (row_ext + SIZE_W'(1) < y_eff) ? row_ext + SIZE_W'(1) : y_eff - SIZE_W'(1);
    assign im = (col_reg == '0) ? '0 : col_reg - POS_W'(1);
    assign jm = (row_reg == '0) ? '0 : row_reg - POS_W'(1);

    // neighbour fetch order: x+1, x-1, y+1, y-1, z-1, centre
    always_comb
    begin
        case (rc_reg)
            3'd0:    raddr = {c, row_reg, ip[POS_W-1:0]};
            3'd1:    raddr = {c, row_reg, im};
            3'd2:    raddr = {c, jp[POS_W-1:0], col_reg};
            3'd3:    raddr = {c, jm, col_reg};
            3'd4:    raddr = {bslot, row_reg, col_reg};
            default: raddr = {c, row_reg, col_reg};
        endcase
    end

    assign waddr = {plane_reg[0], row_reg, col_reg};
    assign we    = (state_reg == T_READ) && (rc_reg == 3'd7) && (op_reg == OP_SAMPLE);

    vgn_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MEM_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (sample_reg),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign above = (op_reg == OP_FLUSH) ? tap_reg[5] : sample_reg;
    assign dx = $signed({1'b0, tap_reg[0]}) - $signed({1'b0, tap_reg[1]});
    assign dy = $signed({1'b0, tap_reg[2]}) - $signed({1'b0, tap_reg[3]});
    assign dz = $signed({1'b0, above}) - $signed({1'b0, tap_reg[4]});

    assign has_res = (op_reg == OP_FLUSH) || (plane_reg != '0);
    assign req     = {(state_reg == T_READ) && (rc_reg == 3'd7) && has_res, fmt_reg};

    vgn_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .dx    (dx),
        .dy    (dy),
        .dz    (dz),
        .done  (core_done),
        .gx    (gx),
        .gy    (gy),
        .gz    (gz)
    );

    assign s_tready  = (state_reg == T_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign col_wrap  = (col_ext + SIZE_W'(1) >= x_eff);
    assign row_wrap  = (row_ext + SIZE_W'(1) >= y_eff);
    assign drain_end = col_wrap && row_wrap;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            T_IDLE:
            begin
                if (in_fire)
                begin
                    // drop samples past the last plane and early flushes
                    if ((s_tuser == OP_SAMPLE) == ({1'b0, plane_reg} < {1'b0, z_eff}))
                        state_next = T_READ;
                end
            end
            T_READ:
            begin
                if (rc_reg == 3'd7)
                    state_next = has_res ? T_CALC : T_IDLE;
            end
            T_CALC:
            begin
                if (core_done)
                    state_next = T_OUT;
            end
            T_OUT:
            begin
                if (!mvalid_reg || m_tready)
                    state_next = T_IDLE;
            end
            default: state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= T_IDLE;
            x_size_reg <= 9'd256;
            y_size_reg <= 9'd256;
            z_size_reg <= 9'd256;
            fmt_reg    <= FMT_BYTE;
            col_reg    <= '0;
            row_reg    <= '0;
            plane_reg  <= '0;
            rc_reg     <= '0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_X_SIZE: x_size_reg <= cfg_data;
                    REG_Y_SIZE: y_size_reg <= cfg_data;
                    REG_Z_SIZE: z_size_reg <= cfg_data;
                    REG_FORMAT: fmt_reg    <= cfg_data[1:0];
                    default:    fmt_reg    <= fmt_reg;
                endcase
                if (cfg_addr != REG_FORMAT)
                begin
                    col_reg   <= '0;
                    row_reg   <= '0;
                    plane_reg <= '0;
                end
            end

            if (state_reg == T_IDLE)
                rc_reg <= '0;
            else if (state_reg == T_READ)
                rc_reg <= rc_reg + 3'd1;

            // advance the raster position once the neighbours are in
            if (state_reg == T_READ && rc_reg == 3'd7)
            begin
                if (op_reg == OP_FLUSH && drain_end)
                begin
                    col_reg   <= '0;
                    row_reg   <= '0;
                    plane_reg <= '0;
                end
                else if (col_wrap)
                begin
                    col_reg <= '0;
                    if (row_wrap)
                    begin
                        row_reg <= '0;
                        if (op_reg == OP_SAMPLE)
                            plane_reg <= plane_reg + PLANE_W'(1);
                    end
                    else
                    begin
                        row_reg <= row_reg + POS_W'(1);
                    end
                end
                else
                begin
                    col_reg <= col_reg + POS_W'(1);
                end
            end

            if (state_reg == T_OUT && (!mvalid_reg || m_tready))
                mvalid_reg <= 1'b1;
            else if (m_tready)
                mvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg     <= s_tuser;
            sample_reg <= s_tdata;
        end
        if (state_reg == T_READ && rc_reg != 3'd0 && rc_reg != 3'd7)
            tap_reg[rc_reg - 3'd1] <= rdata;
        if (state_reg == T_READ && rc_reg == 3'd7)
            last_reg <= (op_reg == OP_FLUSH) && drain_end;
        if (state_reg == T_OUT && (!mvalid_reg || m_tready))
        begin
            mdata_reg <= {5'b0, gz, gy, gx};
            tlast_reg <= last_reg;
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tlast  = tlast_reg;

endmodule

>>> hw/rtl/vgn_ram.sv
module vgn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/vgn_alu.sv
module vgn_alu (
    input  logic [vgn_pkg::ROOT_W-1:0] a,
    input  logic [vgn_pkg::ROOT_W-1:0] b,
    output logic [vgn_pkg::ROOT_W-1:0] diff,
    output logic                       ge
);
    import vgn_pkg::*;

    logic [ROOT_W:0] full;

    // one subtractor: borrow out decides the compare
    assign full = {1'b0, a} - {1'b0, b};
    assign diff = full[ROOT_W-1:0];
    assign ge   = ~full[ROOT_W];

endmodule

>>> hw/rtl/vgn_core.sv
module vgn_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  vgn_pkg::core_req_t                req,
    input  logic signed [vgn_pkg::DIFF_W-1:0] dx,
    input  logic signed [vgn_pkg::DIFF_W-1:0] dy,
    input  logic signed [vgn_pkg::DIFF_W-1:0] dz,
    output logic                              done,
    output logic        [vgn_pkg::GRAD_W-1:0] gx,
    output logic        [vgn_pkg::GRAD_W-1:0] gy,
    output logic        [vgn_pkg::GRAD_W-1:0] gz
);
    import vgn_pkg::*;

    core_state_t       state_reg, state_next;
    logic [DIFF_W-1:0] d_reg [0:2];
    logic [1:0]        fmt_reg;
    logic [1:0]        idx_reg;
    logic [4:0]        cnt_reg;
    logic [SUM_W-1:0]  l_reg;
    logic [ROOT_W-1:0] v_reg;
    logic [ROOT_W-1:0] r_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [QUOT_W-1:0] q_reg;
    logic              zero_reg;
    logic [GRAD_W-1:0] res_reg [0:2];

    logic [DIFF_W-1:0] cur_d, neg_d;
    logic [15:0]       mag;
    logic              neg;
    logic [ROOT_W-1:0] bit_val, alu_a, alu_b, alu_diff;
    logic              alu_ge;
    logic [31:0]       mul_a, mul_b, scale, q_ext, qq;
    logic [63:0]       prod;
    logic [QUOT_W-1:0] qv;
    logic [GRAD_W-1:0] raw, result;

    assign cur_d   = d_reg[idx_reg];
    assign neg_d   = -cur_d;
    assign neg     = cur_d[DIFF_W-1];
    assign mag     = neg ? neg_d[15:0] : cur_d[15:0];
    assign bit_val = ROOT_W'(1) << {cnt_reg, 1'b0};
    assign qv      = zero_reg ? '0 : q_reg;
    assign q_ext   = {1'b0, qv};
    assign qq      = neg ? 32'h4000_0000 - q_ext : 32'h4000_0000 + q_ext;
    assign raw     = neg ? -GRAD_W'(qv) : GRAD_W'(qv);

    always_comb
    begin
        case (fmt_reg)
            FMT_BYTE: scale = SCALE_BYTE;
            FMT_HALF: scale = SCALE_HALF;
            default:  scale = SCALE_WORD;
        endcase
    end

    always_comb
    begin
        if (state_reg == C_SQRT)
        begin
            alu_a = v_reg;
            alu_b = r_reg + bit_val;
        end
        else
        begin
            alu_a = ROOT_W'({rem_reg, 1'b0});
            alu_b = ROOT_W'(r_reg[31:0]);
        end
    end

    vgn_alu u_alu (
        .a    (alu_a),
        .b    (alu_b),
        .diff (alu_diff),
        .ge   (alu_ge)
    );

    always_comb
    begin
        if (state_reg == C_SQ)
        begin
            mul_a = 32'(mag);
            mul_b = 32'(mag);
        end
        else
        begin
            mul_a = scale;
            mul_b = qq;
        end
    end

    assign prod   = mul_a * mul_b;
    assign result = (fmt_reg == FMT_RAW) ? raw : prod[62:30];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            C_IDLE:  if (req.start) state_next = C_SQ;
            C_SQ:    if (idx_reg == 2'd2) state_next = C_RINIT;
            C_RINIT: state_next = C_SQRT;
            C_SQRT:  if (cnt_reg == '0) state_next = C_DINIT;
            C_DINIT: state_next = C_DIV;
            C_DIV:   if (cnt_reg == '0) state_next = C_SCALE;
            C_SCALE: state_next = (idx_reg == 2'd2) ? C_DONE : C_DINIT;
            C_DONE:  state_next = C_IDLE;
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            C_IDLE:
            begin
                d_reg[0] <= dx;
                d_reg[1] <= dy;
                d_reg[2] <= dz;
                fmt_reg  <= req.fmt;
                idx_reg  <= 2'd0;
                l_reg    <= '0;
            end
            C_SQ:
            begin
                l_reg   <= l_reg + prod[SUM_W-1:0];
                idx_reg <= (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
            end
            C_RINIT:
            begin
                v_reg    <= {1'b0, l_reg, 28'b0};
                r_reg    <= '0;
                cnt_reg  <= 5'd31;
                zero_reg <= (l_reg == '0);
            end
            C_SQRT:
            begin
                if (alu_ge)
                begin
                    v_reg <= alu_diff;
                    r_reg <= (r_reg >> 1) + bit_val;
                end
                else
                begin
                    r_reg <= r_reg >> 1;
                end
                cnt_reg <= cnt_reg - 5'd1;
            end
            C_DINIT:
            begin
                rem_reg <= REM_W'({mag, 13'b0});
                q_reg   <= '0;
                cnt_reg <= 5'd30;
            end
            C_DIV:
            begin
                rem_reg <= alu_ge ? alu_diff[REM_W-1:0] : {rem_reg[REM_W-2:0], 1'b0};
                q_reg   <= {q_reg[QUOT_W-2:0], alu_ge};
                cnt_reg <= cnt_reg - 5'd1;
            end
            C_SCALE:
            begin
                res_reg[idx_reg] <= result;
                idx_reg          <= idx_reg + 2'd1;
            end
            default:
            begin
            end
        endcase
    end

    assign done = (state_reg == C_DONE);
    assign gx   = res_reg[0];
    assign gy   = res_reg[1];
    assign gz   = res_reg[2];

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps

module tb;
    import vgn_pkg::*;

    localparam int PLANE_CELLS = 256 * 256;

    typedef struct {
        logic [GRAD_W-1:0] gx;
        logic [GRAD_W-1:0] gy;
        logic [GRAD_W-1:0] gz;
        logic              is_last;
    } grad_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [SAMPLE_W-1:0] s_tdata = '0;
    logic                s_tuser = OP_SAMPLE;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic                m_tlast;
    logic                cfg_we = 1'b0;
    logic [1:0]          cfg_addr = REG_X_SIZE;
    logic [SIZE_W-1:0]   cfg_data = '0;

    // Predictor state: own copy of the plane ring, positions and registers
    logic [SAMPLE_W-1:0] plane_mem [0:2*PLANE_CELLS-1];
    int unsigned         col_at, row_at, plane_at, drain_at;
    logic [SIZE_W-1:0]   sz_x, sz_y, sz_z;
    logic [1:0]          fmt_sel;

    grad_t               grad_fifo [$];
    int                  errors = 0;
    int                  items_sent = 0;
    int                  cyc = 0;
    int                  hold_off = 0;

    always #6 clk = ~clk;

    volume_gradient_normalize u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    // Quiet window: a recurring stretch with no idling on either side
    function automatic bit calm();
        return (cyc % 40000) < 8000;
    endfunction

    // ---------------------------------------------------------------------
    // Gradient predictor
    // ---------------------------------------------------------------------
    function automatic int unsigned clamp_size(logic [SIZE_W-1:0] v);
        if (v == 0)
            return 1;
        return (v > 256) ? 256 : v;
    endfunction

    function automatic longint unsigned int_root(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [GRAD_W-1:0] encode_comp(longint d, longint unsigned len);
        longint unsigned mag;
        longint unsigned q;
        longint unsigned sc;
        mag = (d < 0) ? longint'(-d) : longint'(d);
        q = 0;
        if (len != 0)
            q = (mag << (30 + PREC_SH)) / len;
        if (q > (64'd1 << 30))
            q = 64'd1 << 30;
        if (fmt_sel == FMT_RAW)
            return GRAD_W'((d < 0) ? (64'd0 - q) : q);
        sc = (fmt_sel == FMT_BYTE) ? SCALE_BYTE : (fmt_sel == FMT_HALF) ? SCALE_HALF
                                                                       : SCALE_WORD;
        q = (d < 0) ? ((64'd1 << 30) - q) : ((64'd1 << 30) + q);
        return GRAD_W'((sc * q) >> 30);
    endfunction

    function automatic longint mem_at(int unsigned slot, int unsigned i, int unsigned j);
        return longint'(plane_mem[(slot & 1) * PLANE_CELLS + j * 256 + i]);
    endfunction

    function automatic grad_t central_grad(int unsigned c, int unsigned i, int unsigned j,
                                           longint below, longint above,
                                           int unsigned nx, int unsigned ny);
        grad_t g;
        int unsigned ip, im, jp, jm;
        longint dx, dy, dz;
        longint unsigned l, len;
        ip = (i + 1 < nx) ? i + 1 : nx - 1;
        im = (i > 0) ? i - 1 : 0;
        jp = (j + 1 < ny) ? j + 1 : ny - 1;
        jm = (j > 0) ? j - 1 : 0;
        dx = mem_at(c, ip, j) - mem_at(c, im, j);
        dy = mem_at(c, i, jp) - mem_at(c, i, jm);
        dz = above - below;
        l = dx * dx + dy * dy + dz * dz;
        len = (l == 0) ? 0 : int_root(l << (2 * PREC_SH));
        g.gx = encode_comp(dx, len);
        g.gy = encode_comp(dy, len);
        g.gz = encode_comp(dz, len);
        g.is_last = 1'b0;
        return g;
    endfunction

    // Advance the predictor by one accepted transfer
    task automatic predict_grad(logic op, logic [SAMPLE_W-1:0] smp);
        int unsigned nx, ny, nz, k, c;
        longint below;
        grad_t g;
        nx = clamp_size(sz_x);
        ny = clamp_size(sz_y);
        nz = clamp_size(sz_z);
        if (op == OP_SAMPLE)
        begin
            if (plane_at >= nz)
                return;
            if (plane_at >= 1)
            begin
                k = plane_at - 1;
                c = k & 1;
                below = (k == 0) ? mem_at(c, col_at, row_at) : mem_at(c ^ 1, col_at, row_at);
                g = central_grad(c, col_at, row_at, below, longint'(smp), nx, ny);
                grad_fifo = {grad_fifo, g};
            end
            plane_mem[(plane_at & 1) * PLANE_CELLS + row_at * 256 + col_at] = smp;
            col_at++;
            if (col_at >= nx)
            begin
                col_at = 0;
                row_at++;
                if (row_at >= ny)
                begin
                    row_at = 0;
                    plane_at++;
                end
            end
        end
        else
        begin
            if (plane_at < nz)
                return;
            k = nz - 1;
            c = k & 1;
            below = (k == 0) ? mem_at(c, drain_at % nx, drain_at / nx)
                             : mem_at(c ^ 1, drain_at % nx, drain_at / nx);
            g = central_grad(c, drain_at % nx, drain_at / nx, below,
                             mem_at(c, drain_at % nx, drain_at / nx), nx, ny);
            if (drain_at + 1 >= nx * ny)
            begin
                g.is_last = 1'b1;
                col_at = 0;
                row_at = 0;
                plane_at = 0;
                drain_at = 0;
            end
            else
                drain_at++;
            grad_fifo = {grad_fifo, g};
        end
    endtask

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------
    // Offer one item; we enter just after a posedge
    task automatic send_item(logic op, logic [SAMPLE_W-1:0] smp);
        while (!calm() && $urandom_range(99) < 14)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= smp;
        do
            @(posedge clk);
        while (!s_tready);
        predict_grad(op, smp);
        items_sent++;
    endtask

    // Drop valid and hold until every expected transfer has arrived
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (grad_fifo.size() != 0)
            @(posedge clk);
        // allow for an item with no result still in flight
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [SIZE_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
        if (idx == REG_FORMAT)
            fmt_sel = val[1:0];
        else
        begin
            if (idx == REG_X_SIZE)
                sz_x = val;
            else if (idx == REG_Y_SIZE)
                sz_y = val;
            else
                sz_z = val;
            col_at = 0;
            row_at = 0;
            plane_at = 0;
            drain_at = 0;
        end
        @(posedge clk);
    endtask

    task automatic setup_volume(int x, int y, int z, logic [1:0] f);
        wait_drained();
        write_reg(REG_X_SIZE, SIZE_W'(x));
        write_reg(REG_Y_SIZE, SIZE_W'(y));
        write_reg(REG_Z_SIZE, SIZE_W'(z));
        write_reg(REG_FORMAT, {{(SIZE_W-2){1'b0}}, f});
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample(int mode, logic [SAMPLE_W-1:0] base);
        if (mode == 1)
            return base;
        if (mode == 2)
            return $urandom_range(1) ? 16'hFFFF : 16'h0000;
        return SAMPLE_W'($urandom);
    endfunction

    // Send a whole volume and its drain, with optional ignored items mixed in
    task automatic run_volume(int x, int y, int z, int mode, bit noisy);
        int nx, ny, nz, n;
        logic [SAMPLE_W-1:0] base;
        nx = clamp_size(SIZE_W'(x));
        ny = clamp_size(SIZE_W'(y));
        nz = clamp_size(SIZE_W'(z));
        base = SAMPLE_W'($urandom);
        for (n = 0; n < nx * ny * nz; n++)
        begin
            if (noisy && $urandom_range(9) == 0)
                send_item(OP_FLUSH, SAMPLE_W'($urandom));
            send_item(OP_SAMPLE, pick_sample(mode, base));
        end
        for (n = 0; n < nx * ny; n++)
        begin
            if (noisy && $urandom_range(9) == 0)
                send_item(OP_SAMPLE, SAMPLE_W'($urandom));
            send_item(OP_FLUSH, SAMPLE_W'($urandom));
        end
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------
    task automatic test_directed();
        // 2x2x2 in byte scale: extremes, early flush, sample mid-drain
        setup_volume(2, 2, 2, FMT_BYTE);
        send_item(OP_FLUSH, 16'hFFFF);
        send_item(OP_SAMPLE, 16'h0000);
        send_item(OP_SAMPLE, 16'hFFFF);
        send_item(OP_SAMPLE, 16'hFFFF);
        send_item(OP_SAMPLE, 16'h0000);
        send_item(OP_FLUSH, 16'h0000);
        send_item(OP_SAMPLE, 16'hFFFF);
        send_item(OP_SAMPLE, 16'h0000);
        send_item(OP_SAMPLE, 16'h0000);
        send_item(OP_SAMPLE, 16'hFFFF);
        send_item(OP_FLUSH, 16'h0000);
        send_item(OP_SAMPLE, 16'h1234);
        send_item(OP_FLUSH, 16'h0000);
        send_item(OP_FLUSH, 16'h0000);
        send_item(OP_FLUSH, 16'h0000);
        // single voxel volume: zero vector in half, word and raw scale
        setup_volume(1, 1, 1, FMT_HALF);
        run_volume(1, 1, 1, 0, 1'b0);
        setup_volume(1, 1, 1, FMT_WORD);
        run_volume(1, 1, 1, 0, 1'b0);
        setup_volume(0, 0, 0, FMT_RAW);
        run_volume(0, 0, 0, 0, 1'b0);
    endtask

    // Format changed between planes, positions must be kept
    task automatic test_format_switch();
        int n;
        setup_volume(3, 2, 3, FMT_RAW);
        for (n = 0; n < 12; n++)
            send_item(OP_SAMPLE, SAMPLE_W'($urandom));
        wait_drained();
        write_reg(REG_FORMAT, SIZE_W'(FMT_WORD));
        for (n = 0; n < 6; n++)
            send_item(OP_SAMPLE, SAMPLE_W'($urandom));
        wait_drained();
        write_reg(REG_FORMAT, SIZE_W'(FMT_BYTE));
        for (n = 0; n < 6; n++)
            send_item(OP_FLUSH, 16'h0000);
    endtask

    // Oversized registers act as 256: the first plane ends after 256 voxels
    task automatic test_size_extremes();
        int n;
        setup_volume(511, 1, 2, FMT_RAW);
        for (n = 0; n < 257; n++)
            send_item(OP_SAMPLE, SAMPLE_W'($urandom));
        setup_volume(1, 300, 2, FMT_HALF);
        for (n = 0; n < 257; n++)
            send_item(OP_SAMPLE, pick_sample(2, '0));
        // too many planes: the drain opens after plane 256
        setup_volume(1, 1, 300, FMT_WORD);
        for (n = 0; n < 256; n++)
            send_item(OP_SAMPLE, SAMPLE_W'($urandom));
        send_item(OP_SAMPLE, 16'h0000);
        send_item(OP_FLUSH, 16'h0000);
    endtask

    // Receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        setup_volume(3, 3, 3, FMT_HALF);
        hold_off = 3000;
        run_volume(3, 3, 3, 0, 1'b0);
    endtask

    task automatic test_random();
        int n;
        while (items_sent < 1050)
        begin
            setup_volume($urandom_range(5, 1), $urandom_range(4, 1),
                         $urandom_range(3, 1), 2'($urandom_range(3)));
            if ($urandom_range(9) == 0)
            begin
                // abandon a volume part way through
                for (n = $urandom_range(8, 1); n > 0; n--)
                    send_item(OP_SAMPLE, SAMPLE_W'($urandom));
                continue;
            end
            run_volume(clamp_size(sz_x), clamp_size(sz_y), clamp_size(sz_z),
                       $urandom_range(9) < 7 ? 0 : $urandom_range(2, 1),
                       $urandom_range(3) == 0);
        end
    endtask

    // ---------------------------------------------------------------------
    // Receiver and result checking
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= rst_n && (calm() || $urandom_range(99) >= 14);
    end

    always @(posedge clk)
    begin
        grad_t g;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (grad_fifo.size() == 0)
            begin
                $error("unexpected result transfer");
                errors++;
            end
            else
            begin
                g = grad_fifo.pop_front();
                if (m_tdata[32:0] !== g.gx)
                begin
                    $error("grad_x: expected %h actual %h", g.gx, m_tdata[32:0]);
                    errors++;
                end
                if (m_tdata[65:33] !== g.gy)
                begin
                    $error("grad_y: expected %h actual %h", g.gy, m_tdata[65:33]);
                    errors++;
                end
                if (m_tdata[98:66] !== g.gz)
                begin
                    $error("grad_z: expected %h actual %h", g.gz, m_tdata[98:66]);
                    errors++;
                end
                if (m_tlast !== g.is_last)
                begin
                    $error("last: expected %b actual %b", g.is_last, m_tlast);
                    errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------
    initial
    begin
        for (int n = 0; n < 2 * PLANE_CELLS; n++)
            plane_mem[n] = '0;
        col_at = 0;
        row_at = 0;
        plane_at = 0;
        drain_at = 0;
        sz_x = 9'd256;
        sz_y = 9'd256;
        sz_z = 9'd256;
        fmt_sel = FMT_BYTE;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_format_switch();
        test_backpressure();
        test_size_extremes();
        test_random();

        wait_drained();
        if (errors == 0 && grad_fifo.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #40000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
